// ===== hdl/cfnl_pkg.sv =====
// Shared types, constants and the tag decode for the class file name locator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package cfnl_pkg;

    // Constant pool table geometry and field widths
    localparam int POOL_DEPTH  = 1024;
    localparam int ADDR_W      = $clog2(POOL_DEPTH);
    localparam int PSIZE_W     = $clog2(POOL_DEPTH) + 1;
    localparam int ENTRY_W     = PSIZE_W;
    localparam int OFFSET_BITS = 24;
    localparam int LEN_W       = 16;
    localparam int IDX_W       = 16;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int SKIP_W      = 16;
    localparam int TAG_W       = 5;

    // Output queue
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Parse phases
    localparam logic [3:0] PH_MAGIC   = 4'd0;
    localparam logic [3:0] PH_VERSION = 4'd1;
    localparam logic [3:0] PH_COUNT   = 4'd2;
    localparam logic [3:0] PH_TAG     = 4'd3;
    localparam logic [3:0] PH_PAYLOAD = 4'd4;
    localparam logic [3:0] PH_ULEN    = 4'd5;
    localparam logic [3:0] PH_UDATA   = 4'd6;
    localparam logic [3:0] PH_ACCESS  = 4'd7;
    localparam logic [3:0] PH_THIS    = 4'd8;
    localparam logic [3:0] PH_DONE    = 4'd9;

    // Pool entry kinds
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLASS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UTF8  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_TAG   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd3;
    localparam logic [STATUS_W-1:0] ST_POOL_BIG  = 3'd4;

    // Constant pool tags with special handling
    localparam logic [7:0] TAG_UTF8   = 8'd1;
    localparam logic [7:0] TAG_LONG   = 8'd5;
    localparam logic [7:0] TAG_DOUBLE = 8'd6;
    localparam logic [7:0] TAG_CLASS  = 8'd7;

    // Header layout
    localparam logic [31:0] MAGIC_WORD = 32'hCAFEBABE;
    localparam logic [OFFSET_BITS-1:0] MAGIC_LAST_POS   = OFFSET_BITS'(3);
    localparam logic [OFFSET_BITS-1:0] VERSION_LAST_POS = OFFSET_BITS'(7);
    localparam logic [OFFSET_BITS-1:0] COUNT_LAST_POS   = OFFSET_BITS'(9);
    localparam logic [SKIP_W-1:0]      ACCESS_BYTES     = SKIP_W'(2);
    localparam logic [SKIP_W-1:0]      THIS_BYTES       = SKIP_W'(2);

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [LEN_W-1:0]       len;
        logic [OFFSET_BITS-1:0] off;
    } pool_entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        pool_entry_t       data;
    } pool_wr_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic                lookup;
        logic [IDX_W-1:0]    cidx;
        logic [PSIZE_W-1:0]  psize;
    } event_t;

    // Last member sits in the lowest bits: status first from bit 0 up
    typedef struct packed {
        logic [IDX_W-1:0]       class_index;
        logic [LEN_W-1:0]       name_length;
        logic [OFFSET_BITS-1:0] name_offset;
        logic [STATUS_W-1:0]    status;
    } result_t;

    localparam int RESULT_W     = $bits(result_t);
    localparam int OUT_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // Payload byte count that follows a tag; zero marks an invalid tag
    function automatic logic [3:0] payload_size(input logic [7:0] tag);
        logic [3:0] n;
        case (tag)
            8'd7, 8'd8, 8'd16, 8'd19, 8'd20:                  n = 4'd2;
            8'd15:                                            n = 4'd3;
            8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12,
            8'd14, 8'd17, 8'd18:                              n = 4'd4;
            8'd5, 8'd6:                                       n = 4'd8;
            8'd1:                                             n = 4'd2;
            default:                                          n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/cfnl_parser.sv =====
// Input word register and byte-level class file parser for the name locator.
// Depends on cfnl_pkg; drives pool table writes and result events.
`timescale 1ns / 1ps

module cfnl_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              busy,
    output cfnl_pkg::event_t  evt,
    output cfnl_pkg::pool_wr_t wr
);
    import cfnl_pkg::*;

    logic                   s0_valid_reg;
    logic [7:0]             s0_byte_reg;
    logic                   s0_last_reg;

    logic [3:0]             phase_reg,  phase_next;
    logic [OFFSET_BITS-1:0] pos_reg,    pos_next;
    logic [SKIP_W-1:0]      skip_reg,   skip_next;
    logic [TAG_W-1:0]       tag_reg,    tag_next;
    logic [31:0]            word_reg,   word_next;
    logic [ENTRY_W-1:0]     entry_reg,  entry_next;
    logic [PSIZE_W-1:0]     psize_reg,  psize_next;
    pool_wr_t               pend_reg,   pend_next;

    logic [SKIP_W-1:0]      skip_dec;
    logic [3:0]             tag_size;
    logic [15:0]            word16;
    logic                   fin;
    logic                   emit;
    logic [STATUS_W-1:0]    st;
    logic                   lookup;
    pool_wr_t               main_wr;
    logic [ENTRY_W-1:0]     entry_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s0_byte_reg <= in_byte;
            s0_last_reg <= in_last;
        end
    end

    assign skip_dec = skip_reg - SKIP_W'(1);
    assign tag_size = payload_size(s0_byte_reg);
    assign word16   = {word_reg[7:0], s0_byte_reg};

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        skip_next  = skip_reg;
        tag_next   = tag_reg;
        word_next  = word_reg;
        entry_next = entry_reg;
        psize_next = psize_reg;
        pend_next  = '0;
        main_wr    = '0;
        fin        = 1'b0;
        emit       = 1'b0;
        st         = ST_OK;
        lookup     = 1'b0;
        entry_step = ENTRY_W'(1);

        if (s0_valid_reg && (phase_reg != PH_DONE))
        begin
            case (phase_reg)
                PH_MAGIC:
                begin
                    word_next = {word_reg[23:0], s0_byte_reg};
                    if (pos_reg >= MAGIC_LAST_POS)
                    begin
                        if (word_next != MAGIC_WORD)
                        begin
                            emit = 1'b1;
                            st   = ST_BAD_MAGIC;
                        end
                        else
                        begin
                            phase_next = PH_VERSION;
                        end
                    end
                end
                PH_VERSION:
                begin
                    if (pos_reg >= VERSION_LAST_POS)
                    begin
                        phase_next = PH_COUNT;
                        word_next  = '0;
                    end
                end
                PH_COUNT:
                begin
                    word_next = {16'd0, word16};
                    if (pos_reg >= COUNT_LAST_POS)
                    begin
                        if (32'(word16) > 32'(POOL_DEPTH))
                        begin
                            emit = 1'b1;
                            st   = ST_POOL_BIG;
                        end
                        else
                        begin
                            psize_next = PSIZE_W'(word16);
                            entry_next = ENTRY_W'(1);
                            if (word16 <= 16'd1)
                            begin
                                phase_next = PH_ACCESS;
                                skip_next  = ACCESS_BYTES;
                            end
                            else
                            begin
                                phase_next = PH_TAG;
                            end
                        end
                    end
                end
                PH_TAG:
                begin
                    if (tag_size == 4'd0)
                    begin
                        emit = 1'b1;
                        st   = ST_BAD_TAG;
                    end
                    else
                    begin
                        tag_next   = s0_byte_reg[TAG_W-1:0];
                        word_next  = '0;
                        skip_next  = SKIP_W'(tag_size);
                        phase_next = (s0_byte_reg == TAG_UTF8) ? PH_ULEN : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    word_next = {word_reg[23:0], s0_byte_reg};
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        main_wr.en   = 1'b1;
                        main_wr.addr = entry_reg[ADDR_W-1:0];
                        if (tag_reg == TAG_CLASS[TAG_W-1:0])
                        begin
                            main_wr.data.kind = KIND_CLASS;
                            main_wr.data.len  = word_next[15:0];
                        end
                        fin = 1'b1;
                    end
                end
                PH_ULEN:
                begin
                    word_next = {16'd0, word16};
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        main_wr.en        = 1'b1;
                        main_wr.addr      = entry_reg[ADDR_W-1:0];
                        main_wr.data.kind = KIND_UTF8;
                        main_wr.data.len  = word16;
                        main_wr.data.off  = pos_reg + OFFSET_BITS'(1);
                        if (word16 == 16'd0)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            skip_next  = word16;
                            phase_next = PH_UDATA;
                        end
                    end
                end
                PH_UDATA:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        fin = 1'b1;
                    end
                end
                PH_ACCESS:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = PH_THIS;
                        skip_next  = THIS_BYTES;
                        word_next  = '0;
                    end
                end
                PH_THIS:
                begin
                    word_next = {16'd0, word16};
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        emit   = 1'b1;
                        st     = ST_BAD_INDEX;
                        lookup = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // Close an entry; Long and Double take a second slot
            if (fin)
            begin
                if ((tag_reg == TAG_LONG[TAG_W-1:0]) || (tag_reg == TAG_DOUBLE[TAG_W-1:0]))
                begin
                    entry_step = ENTRY_W'(2);
                    if ((entry_reg + ENTRY_W'(1)) < ENTRY_W'(psize_reg))
                    begin
                        pend_next.en   = 1'b1;
                        pend_next.addr = ADDR_W'(entry_reg + ENTRY_W'(1));
                    end
                end
                entry_next = entry_reg + entry_step;
                if (entry_next >= ENTRY_W'(psize_reg))
                begin
                    phase_next = PH_ACCESS;
                    skip_next  = ACCESS_BYTES;
                end
                else
                begin
                    phase_next = PH_TAG;
                end
            end

            pos_next = pos_reg + OFFSET_BITS'(1);
            if (emit)
            begin
                phase_next = PH_DONE;
            end
        end

        // End of file: restart for the next file
        if (s0_valid_reg && s0_last_reg)
        begin
            phase_next = PH_MAGIC;
            pos_next   = '0;
            skip_next  = '0;
            tag_next   = '0;
            word_next  = '0;
            entry_next = '0;
            psize_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            pos_reg   <= '0;
            skip_reg  <= '0;
            tag_reg   <= '0;
            word_reg  <= '0;
            entry_reg <= '0;
            psize_reg <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            skip_reg  <= skip_next;
            tag_reg   <= tag_next;
            word_reg  <= word_next;
            entry_reg <= entry_next;
            psize_reg <= psize_next;
            pend_reg  <= pend_next;
        end
    end

    // A deferred second-slot write never meets an entry write in the same cycle
    assign wr = main_wr.en ? main_wr : pend_reg;

    always_comb
    begin
        evt        = '0;
        evt.status = st;
        evt.lookup = lookup;
        evt.cidx   = lookup ? word16 : '0;
        evt.psize  = psize_reg;
        if (s0_valid_reg && (phase_reg != PH_DONE))
        begin
            evt.valid = emit || s0_last_reg;
            if (!emit)
            begin
                evt.status = ST_BAD_INDEX;
                evt.lookup = 1'b0;
                evt.cidx   = '0;
            end
        end
    end

    assign busy = s0_valid_reg;

endmodule

// ===== hdl/cfnl_resolve.sv =====
// Constant pool table and the two-step this_class to Utf8 resolution pipeline.
// Depends on cfnl_pkg; fed by cfnl_parser, feeds cfnl_outq.
`timescale 1ns / 1ps

module cfnl_resolve
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfnl_pkg::event_t   evt,
    input  cfnl_pkg::pool_wr_t wr,
    output logic [1:0]         busy,
    output logic               push,
    output cfnl_pkg::result_t  res
);
    import cfnl_pkg::*;

    pool_entry_t pool_mem [POOL_DEPTH];
    pool_entry_t rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic   p1_valid_reg;
    event_t p1_evt_reg;
    logic   p1_ok_reg;
    logic   p2_valid_reg;
    event_t p2_evt_reg;
    logic   p2_ok_reg;

    logic   ok0;
    logic   ok1;
    logic [LEN_W-1:0] name_idx;

    // Step one: this_class must lie inside the pool
    assign ok0 = (evt.cidx != '0) && (32'(evt.cidx) < 32'(evt.psize));

    // Step two: the Class entry must point at a valid slot
    assign name_idx = rd_data_reg.len;
    assign ok1 = p1_ok_reg && (rd_data_reg.kind == KIND_CLASS) && (name_idx != '0)
                 && (32'(name_idx) < 32'(p1_evt_reg.psize));

    // Lookups are many bytes apart, so the two steps never want the port together
    assign rd_addr = (p1_valid_reg && p1_evt_reg.lookup) ? name_idx[ADDR_W-1:0]
                                                         : evt.cidx[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            pool_mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= pool_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= evt.valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_evt_reg <= evt;
        p1_ok_reg  <= ok0;
        p2_evt_reg <= p1_evt_reg;
        p2_ok_reg  <= ok1;
    end

    always_comb
    begin
        res             = '0;
        res.status      = p2_evt_reg.status;
        res.class_index = p2_evt_reg.cidx;
        if (p2_evt_reg.lookup && p2_ok_reg && (rd_data_reg.kind == KIND_UTF8))
        begin
            res.status      = ST_OK;
            res.name_offset = rd_data_reg.off;
            res.name_length = rd_data_reg.len;
        end
    end

    assign push = p2_valid_reg;
    assign busy = 2'(p1_valid_reg) + 2'(p2_valid_reg);

endmodule

// ===== hdl/cfnl_outq.sv =====
// Small result queue that decouples the result pipeline from the output stream.
// Depends on cfnl_pkg.
`timescale 1ns / 1ps

module cfnl_outq
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  cfnl_pkg::result_t         push_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output cfnl_pkg::result_t         out_data,
    output logic [cfnl_pkg::QCNT_W-1:0] count
);
    import cfnl_pkg::*;

    result_t           q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = q_mem[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

// ===== hdl/class_file_name_locator_core.sv =====
// A result passes the input register, the parse, the Class entry read, the Utf8 entry
// read and the result queue before it leaves once the output is ready.
// Throughput: one byte per cycle; the 8-word result queue and a credit count over
// the in-flight words set when input stalls under output backpressure.
// Reset (rst_n, async, active low): parser returns to the magic phase, queue empties;
// the constant pool table is not cleared, every slot read is written first.
`timescale 1ns / 1ps

module class_file_name_locator_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // [7:0] data_byte
    input  logic                               s_tlast,  // end_of_file
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cfnl_pkg::OUT_TDATA_W-1:0]   m_tdata   // status, name_offset,
                                                         // name_length, class_index
);
    import cfnl_pkg::*;

    event_t            evt;
    pool_wr_t          pool_wr;
    logic              parse_busy;
    logic [1:0]        resolve_busy;
    logic              res_push;
    result_t           res;
    result_t           q_data;
    logic [QCNT_W-1:0] q_count;
    logic [QCNT_W:0]   words_held;
    logic              accept;

    // Take a word only while the queue has room for every word that may still
    // turn into a result: queued ones plus the ones in the parse and lookup stages.
    assign words_held = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(parse_busy)
                        + (QCNT_W+1)'(resolve_busy);
    assign s_tready   = (words_held < (QCNT_W+1)'(QDEPTH));
    assign accept     = s_tvalid && s_tready;

    // Byte parser: walks the header and the constant pool, fills the table
    cfnl_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .busy     (parse_busy),
        .evt      (evt),
        .wr       (pool_wr)
    );

    // Table plus the this_class -> Class -> Utf8 resolution
    cfnl_resolve u_resolve
    (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .wr    (pool_wr),
        .busy  (resolve_busy),
        .push  (res_push),
        .res   (res)
    );

    // Hold finished results until the downstream side takes them
    cfnl_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (q_data),
        .count     (q_count)
    );

    assign m_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, q_data};

endmodule

// ===== hdl/cfnl_checker.sv =====
// Port-level checks on the name locator's output stream, bound to the top level.
// Depends on cfnl_pkg and class_file_name_locator_core.
`timescale 1ns / 1ps

module cfnl_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [7:0]                       s_tdata,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [cfnl_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import cfnl_pkg::*;

    result_t r;
    logic    in_seen;

    assign r       = m_tdata[RESULT_W-1:0];
    assign in_seen = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tlast == s_tlast);

    // Hold the word while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Only a resolved name carries an offset and a length
    a_span_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (r.status != ST_OK) |-> (r.name_offset == '0) && (r.name_length == '0))
        else $error("name span on a failed result");

    // A resolved name comes from a nonzero this_class
    a_ok_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (r.status == ST_OK) |-> (r.class_index != '0))
        else $error("ok result with zero class index");

    // Header and tag failures come before this_class is read
    a_early_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((r.status == ST_BAD_MAGIC) || (r.status == ST_BAD_TAG)
                     || (r.status == ST_POOL_BIG)) |-> (r.class_index == '0))
        else $error("class index on an early failure");

    // Right at reset release, no output word shows unless an input word is taken
    a_no_early_out: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid || in_seen)
        else $error("output word right out of reset");

endmodule

bind class_file_name_locator_core cfnl_checker u_cfnl_checker (.*);

// ===== verif/tb_class_file_name_locator_core.sv =====
// Self-checking bench for class_file_name_locator_core: streams class files one word per
// byte and checks every name span word against a shadow parser or the directed table.
// Depends on cfnl_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_class_file_name_locator_core;

    import cfnl_pkg::*;

    localparam int QUIET_LIMIT = 3000;  // cycles with no word moved before giving up
    localparam int HOLD_CYCLES = 300;   // long output hold-off that backs up the core
    localparam int FLUSH_CYCLES = 20;   // drain time left for stray words to show up
    localparam int RANDOM_BYTES = 1800;
    localparam int RANDOM_FILES = 60;

    // Every tag the pool walk accepts; Class and Utf8 lead so a full sweep can resolve
    localparam int GOOD_TAGS [18] = '{7, 1, 3, 4, 5, 6, 8, 9, 10, 11, 12, 14, 15, 16, 17,
                                      18, 19, 20};
    // Holes in the tag space below 21
    localparam logic [7:0] HOLE_TAGS [3] = '{8'd0, 8'd2, 8'd13};

    typedef enum logic [3:0] {
        FILE_EOF_ONLY,
        FILE_BAD_MAGIC,
        FILE_POOL_BIG,
        FILE_BAD_TAG,
        FILE_EMPTY_POOL,
        FILE_GOOD,
        FILE_LONG_LAST,
        FILE_ALL_TAGS,
        FILE_FULL_POOL,
        FILE_CUT_SHORT
    } file_case_e;

    // One directed file: a and c are per-case knobs (count, tag, xor mask, this_class)
    typedef struct packed {
        file_case_e          kind;
        logic [15:0]         a;
        logic [15:0]         c;
        logic                typed;
        logic [STATUS_W-1:0] want_status;
    } file_row_t;

    // One byte of the input stream plus what the bench needs to know about it
    typedef struct packed {
        logic [7:0] b;
        logic       eof;
        logic       typed;  // span word for this file is fixed by the table
        result_t    want;
        logic       burst;  // offer with no gap
        logic       hold;   // start the long output hold-off when offered
    } file_byte_t;

    // Directed files; status is typed in only where it is obvious from the format
    localparam file_row_t DIRECTED [18] = '{
        '{FILE_EOF_ONLY,   16'h00FF, 16'h0000, 1'b1, ST_BAD_INDEX},
        '{FILE_EOF_ONLY,   16'h0000, 16'h0000, 1'b1, ST_BAD_INDEX},
        '{FILE_BAD_MAGIC,  16'h0001, 16'h0000, 1'b1, ST_BAD_MAGIC},
        '{FILE_BAD_MAGIC,  16'h8000, 16'h0000, 1'b1, ST_BAD_MAGIC},
        '{FILE_POOL_BIG,   16'h0401, 16'h0000, 1'b1, ST_POOL_BIG},
        '{FILE_POOL_BIG,   16'hFFFF, 16'h0000, 1'b1, ST_POOL_BIG},
        '{FILE_BAD_TAG,    16'h0000, 16'h0000, 1'b1, ST_BAD_TAG},
        '{FILE_BAD_TAG,    16'h0002, 16'h0000, 1'b1, ST_BAD_TAG},
        '{FILE_BAD_TAG,    16'h000D, 16'h0000, 1'b1, ST_BAD_TAG},
        '{FILE_BAD_TAG,    16'h0015, 16'h0000, 1'b1, ST_BAD_TAG},
        '{FILE_BAD_TAG,    16'h00FF, 16'h0000, 1'b1, ST_BAD_TAG},
        '{FILE_EMPTY_POOL, 16'h0000, 16'h0000, 1'b1, ST_BAD_INDEX},
        '{FILE_EMPTY_POOL, 16'h0001, 16'hFFFF, 1'b1, ST_BAD_INDEX},
        '{FILE_GOOD,       16'h0001, 16'h0000, 1'b0, ST_OK},
        '{FILE_LONG_LAST,  16'h0005, 16'h0000, 1'b0, ST_OK},
        '{FILE_LONG_LAST,  16'h0006, 16'h0000, 1'b0, ST_OK},
        '{FILE_ALL_TAGS,   16'h0015, 16'h0000, 1'b0, ST_OK},
        '{FILE_CUT_SHORT,  16'h0005, 16'h0000, 1'b1, ST_BAD_INDEX}
    };

    logic clk;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'h00;  // [7:0] data_byte
    logic s_tlast = 1'b0;         // end_of_file
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;  // status, name_offset, name_length, class_index

    // Side info that travels with the offered word
    logic in_typed = 1'b0;
    result_t in_want = '0;

    // Stimulus build state
    file_byte_t stim_q [$];
    logic cur_typed;
    result_t cur_want;
    logic cur_burst;
    logic cur_hold;

    // Shadow parser state
    logic [3:0] ps_phase;
    logic [OFFSET_BITS-1:0] ps_pos;
    logic [SKIP_W-1:0] ps_skip;
    logic [TAG_W-1:0] ps_tag;
    logic [31:0] ps_acc;
    int unsigned ps_entry;
    int unsigned ps_count;
    bit ps_done;
    pool_entry_t pool_shadow [POOL_DEPTH];

    result_t pending_spans [$];  // name span words still owed by the core
    int errors = 0;
    int quiet = 0;
    bit hold_req = 1'b0;
    bit hold_rx = 1'b0;

    // Monitor scratch
    bit mon_got;
    result_t mon_res;
    result_t mon_seen;
    result_t mon_want;

    class_file_name_locator_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow parser
    // ------------------------------------------------------------------

    function automatic int tag_payload(input logic [7:0] t);
        case (t)
            8'd7, 8'd8, 8'd16, 8'd19, 8'd20:                 return 2;
            8'd15:                                           return 3;
            8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12,
            8'd14, 8'd17, 8'd18:                             return 4;
            8'd5, 8'd6:                                      return 8;
            8'd1:                                            return 2;
            default:                                         return 0;
        endcase
    endfunction

    // Return everything but the pool table to its idle state
    task automatic restart_parse();
        ps_phase = PH_MAGIC;
        ps_pos = '0;
        ps_skip = '0;
        ps_tag = '0;
        ps_acc = '0;
        ps_entry = 0;
        ps_count = 0;
        ps_done = 1'b0;
    endtask

    task automatic store_slot(input int unsigned ix, input logic [KIND_W-1:0] kind,
                              input logic [LEN_W-1:0] len, input logic [OFFSET_BITS-1:0] off);
        if (ix < POOL_DEPTH)
            pool_shadow[ix] = '{kind: kind, len: len, off: off};
    endtask

    // Close the current pool entry; Long and Double take two slots
    task automatic close_entry();
        int unsigned stride;
        stride = 1;
        if (ps_tag == TAG_LONG[TAG_W-1:0] || ps_tag == TAG_DOUBLE[TAG_W-1:0])
        begin
            stride = 2;
            if (ps_entry + 1 < ps_count)
                store_slot(ps_entry + 1, KIND_OTHER, '0, '0);
        end
        ps_entry += stride;
        if (ps_entry >= ps_count)
        begin
            ps_phase = PH_ACCESS;
            ps_skip = ACCESS_BYTES;
        end
        else
            ps_phase = PH_TAG;
    endtask

    // Advance the shadow parser by one byte; got marks a span word owed for it
    task automatic parse_class_byte(input logic [7:0] b, input logic eof,
                                    output bit got, output result_t r);
        logic [OFFSET_BITS-1:0] pos;
        int n;
        logic [IDX_W-1:0] ci;
        logic [LEN_W-1:0] ni;
        pool_entry_t ce;
        pool_entry_t ue;
        got = 1'b0;
        r = '0;
        pos = ps_pos;
        // After a verdict, drop bytes until the end of the file
        if (ps_phase == PH_DONE || ps_done)
        begin
            if (eof)
                restart_parse();
            return;
        end
        case (ps_phase)
            PH_MAGIC:
            begin
                ps_acc = {ps_acc[23:0], b};
                if (pos >= MAGIC_LAST_POS)
                begin
                    if (ps_acc != MAGIC_WORD)
                    begin
                        got = 1'b1;
                        r.status = ST_BAD_MAGIC;
                    end
                    else
                        ps_phase = PH_VERSION;
                end
            end
            PH_VERSION:
            begin
                if (pos >= VERSION_LAST_POS)
                begin
                    ps_phase = PH_COUNT;
                    ps_acc = '0;
                end
            end
            PH_COUNT:
            begin
                ps_acc = {16'h0, ps_acc[7:0], b};
                if (pos >= COUNT_LAST_POS)
                begin
                    ps_count = ps_acc[15:0];
                    if (ps_count > POOL_DEPTH)
                    begin
                        got = 1'b1;
                        r.status = ST_POOL_BIG;
                    end
                    else
                    begin
                        ps_entry = 1;
                        if (ps_count <= 1)
                        begin
                            ps_phase = PH_ACCESS;
                            ps_skip = ACCESS_BYTES;
                        end
                        else
                            ps_phase = PH_TAG;
                    end
                end
            end
            PH_TAG:
            begin
                n = tag_payload(b);
                if (n == 0)
                begin
                    got = 1'b1;
                    r.status = ST_BAD_TAG;
                end
                else
                begin
                    ps_tag = b[TAG_W-1:0];
                    ps_acc = '0;
                    ps_skip = SKIP_W'(n);
                    ps_phase = (b == TAG_UTF8) ? PH_ULEN : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                ps_acc = {ps_acc[23:0], b};
                ps_skip = ps_skip - 1'b1;
                if (ps_skip == 0)
                begin
                    if (ps_tag == TAG_CLASS[TAG_W-1:0])
                        store_slot(ps_entry, KIND_CLASS, ps_acc[15:0], '0);
                    else
                        store_slot(ps_entry, KIND_OTHER, '0, '0);
                    close_entry();
                end
            end
            PH_ULEN:
            begin
                ps_acc = {16'h0, ps_acc[7:0], b};
                ps_skip = ps_skip - 1'b1;
                if (ps_skip == 0)
                begin
                    store_slot(ps_entry, KIND_UTF8, ps_acc[15:0], pos + 1'b1);
                    if (ps_acc[15:0] == 0)
                        close_entry();
                    else
                    begin
                        ps_skip = ps_acc[15:0];
                        ps_phase = PH_UDATA;
                    end
                end
            end
            PH_UDATA:
            begin
                ps_skip = ps_skip - 1'b1;
                if (ps_skip == 0)
                    close_entry();
            end
            PH_ACCESS:
            begin
                ps_skip = ps_skip - 1'b1;
                if (ps_skip == 0)
                begin
                    ps_phase = PH_THIS;
                    ps_skip = THIS_BYTES;
                    ps_acc = '0;
                end
            end
            PH_THIS:
            begin
                ps_acc = {16'h0, ps_acc[7:0], b};
                ps_skip = ps_skip - 1'b1;
                if (ps_skip == 0)
                begin
                    // Resolve this_class through its Class entry to the Utf8 name
                    ci = ps_acc[15:0];
                    got = 1'b1;
                    r.status = ST_BAD_INDEX;
                    r.class_index = ci;
                    if (ci != 0 && ci < ps_count)
                    begin
                        ce = pool_shadow[ci];
                        if (ce.kind == KIND_CLASS)
                        begin
                            ni = ce.len;
                            if (ni != 0 && ni < ps_count)
                            begin
                                ue = pool_shadow[ni];
                                if (ue.kind == KIND_UTF8)
                                begin
                                    r.status = ST_OK;
                                    r.name_offset = ue.off;
                                    r.name_length = ue.len;
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        ps_pos = pos + 1'b1;

        if (got)
        begin
            ps_phase = PH_DONE;
            ps_done = 1'b1;
        end
        else if (eof)
        begin
            // File ended before any verdict
            got = 1'b1;
            r = '0;
            r.status = ST_BAD_INDEX;
        end
        if (eof)
            restart_parse();
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    task automatic add_byte(input logic [7:0] b, input logic eof);
        stim_q.push_back('{b, eof, cur_typed, cur_want, cur_burst, cur_hold});
        cur_hold = 1'b0;
    endtask

    task automatic add_word16(input logic [15:0] v, input logic eof);
        add_byte(v[15:8], 1'b0);
        add_byte(v[7:0], eof);
    endtask

    task automatic add_header(input logic [15:0] count);
        logic [31:0] ver;
        ver = $urandom;
        add_word16(MAGIC_WORD[31:16], 1'b0);
        add_word16(MAGIC_WORD[15:0], 1'b0);
        add_word16(ver[31:16], 1'b0);
        add_word16(ver[15:0], 1'b0);
        add_word16(count, 1'b0);
    endtask

    function automatic int pick_tag();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return TAG_UTF8;
        if (r < 5)
            return TAG_CLASS;
        return GOOD_TAGS[$urandom_range(0, 17)];
    endfunction

    // Mostly short names, now and then one with a nonzero high length byte
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return $urandom_range(0, 10);
        if (r < 98)
            return $urandom_range(11, 300);
        return $urandom_range(256, 700);
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return $urandom_range(0, 1);
        if (r < 85)
            return $urandom_range(2, 12);
        return $urandom_range(13, 60);
    endfunction

    // Well-formed file with a random pool; Class entries mostly name a Utf8 slot and
    // this_class mostly names a Class slot, so most files resolve
    task automatic build_pool_file(input int count, input bit all_tags);
        int tags [$];
        int utf8_at [$];
        int class_at [$];
        int slot;
        int j;
        int t;
        int len;
        int tail;
        logic [15:0] ix;
        add_header(count[15:0]);
        slot = 1;
        j = 0;
        while (slot < count)
        begin
            t = all_tags ? GOOD_TAGS[j % 18] : pick_tag();
            tags.push_back(t);
            if (t == TAG_UTF8)
                utf8_at.push_back(slot);
            if (t == TAG_CLASS)
                class_at.push_back(slot);
            slot += (t == TAG_LONG || t == TAG_DOUBLE) ? 2 : 1;
            j++;
        end
        for (j = 0; j < tags.size(); j++)
        begin
            t = tags[j];
            add_byte(t[7:0], 1'b0);
            if (t == TAG_UTF8)
            begin
                len = pick_len();
                add_word16(len[15:0], 1'b0);
                repeat (len) add_byte($urandom, 1'b0);
            end
            else if (t == TAG_CLASS)
            begin
                if (utf8_at.size() > 0 && $urandom_range(0, 9) != 0)
                    ix = utf8_at[$urandom_range(0, utf8_at.size() - 1)];
                else if ($urandom_range(0, 3) == 0)
                    ix = $urandom;
                else
                    ix = $urandom_range(0, count);
                add_word16(ix, 1'b0);
            end
            else
                repeat (tag_payload(t[7:0])) add_byte($urandom, 1'b0);
        end
        add_word16($urandom, 1'b0);
        if (class_at.size() > 0 && $urandom_range(0, 6) != 0)
            ix = class_at[$urandom_range(0, class_at.size() - 1)];
        else if ($urandom_range(0, 1) == 0)
            ix = $urandom;
        else
            ix = $urandom_range(0, count);
        tail = $urandom_range(0, 3);
        add_word16(ix, tail == 0);
        for (j = 1; j <= tail; j++)
            add_byte($urandom, j == tail);
    endtask

    task automatic build_row(input file_row_t row);
        logic [31:0] word;
        cur_typed = row.typed;
        cur_want = '0;
        cur_want.status = row.want_status;
        if (row.kind == FILE_EMPTY_POOL)
            cur_want.class_index = row.c;
        case (row.kind)
            FILE_EOF_ONLY:
                add_byte(row.a[7:0], 1'b1);
            FILE_BAD_MAGIC:
            begin
                // Trailing bytes must be ignored after the verdict
                word = MAGIC_WORD ^ {row.a, row.a};
                add_word16(word[31:16], 1'b0);
                add_word16(word[15:0], 1'b0);
                add_byte(8'hFF, 1'b0);
                add_byte(8'h00, 1'b1);
            end
            FILE_POOL_BIG:
            begin
                add_header(row.a);
                add_byte(8'hAA, 1'b1);
            end
            FILE_BAD_TAG:
            begin
                add_header(16'd3);
                add_byte(row.a[7:0], 1'b0);
                add_byte(8'h55, 1'b1);
            end
            FILE_EMPTY_POOL:
            begin
                add_header(row.a);
                add_word16(16'h0021, 1'b0);
                add_word16(row.c, 1'b1);
            end
            FILE_GOOD, FILE_LONG_LAST:
            begin
                // Class at slot 1 names the Utf8 at slot 2; a wide entry may close the pool
                add_header(row.kind == FILE_GOOD ? 16'd3 : 16'd4);
                add_byte(TAG_CLASS, 1'b0);
                add_word16(16'd2, 1'b0);
                add_byte(TAG_UTF8, 1'b0);
                if (row.kind == FILE_GOOD)
                begin
                    add_word16(row.a, 1'b0);
                    repeat (row.a) add_byte($urandom, 1'b0);
                end
                else
                begin
                    add_word16(16'd3, 1'b0);
                    repeat (3) add_byte($urandom, 1'b0);
                    add_byte(row.a[7:0], 1'b0);
                    repeat (8) add_byte($urandom, 1'b0);
                end
                add_word16(16'h0021, 1'b0);
                add_word16(16'd1, 1'b1);
            end
            FILE_ALL_TAGS:
                build_pool_file(row.a, 1'b1);
            FILE_FULL_POOL:
                build_pool_file(POOL_DEPTH, 1'b0);
            FILE_CUT_SHORT:
            begin
                add_header(row.a);
                add_byte(TAG_CLASS, 1'b0);
                add_byte(8'h01, 1'b1);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic build_random_files();
        int start;
        int keep;
        int r;
        int rand_bytes;
        int rand_files;
        logic [31:0] word;
        file_byte_t fin;
        rand_bytes = 0;
        rand_files = 0;
        cur_typed = 1'b0;
        cur_want = '0;
        while (rand_bytes < RANDOM_BYTES || rand_files < RANDOM_FILES)
        begin
            start = stim_q.size();
            cur_burst = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 78)
                build_pool_file(pick_count(), 1'b0);
            else if (r < 86)
            begin
                // Drop the tail of a good file and end it early
                build_pool_file($urandom_range(2, 8), 1'b0);
                keep = $urandom_range(1, stim_q.size() - start - 1);
                while (stim_q.size() > start + keep)
                    fin = stim_q.pop_back();
                fin = stim_q.pop_back();
                fin.eof = 1'b1;
                stim_q.push_back(fin);
            end
            else if (r < 89)
            begin
                word = $urandom;
                add_word16(word[31:16], 1'b0);
                add_word16(word[15:0], 1'b0);
                add_byte($urandom, 1'b1);
            end
            else if (r < 93)
            begin
                add_header($urandom_range(2, 20));
                if ($urandom_range(0, 1) == 0)
                    add_byte(HOLE_TAGS[$urandom_range(0, 2)], 1'b0);
                else
                    add_byte($urandom_range(21, 255), 1'b0);
                add_byte($urandom, 1'b1);
            end
            else if (r < 96)
            begin
                add_header($urandom_range(POOL_DEPTH + 1, 65535));
                add_byte($urandom, 1'b1);
            end
            else
            begin
                keep = $urandom_range(1, 12);
                for (r = 1; r <= keep; r++)
                    add_byte($urandom, r == keep);
            end
            rand_bytes += stim_q.size() - start;
            rand_files++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: build, reset, drive, drain
    // ------------------------------------------------------------------
    initial
    begin
        int idx;
        int gap;
        file_byte_t it;
        cur_typed = 1'b0;
        cur_want = '0;
        cur_burst = 1'b0;
        cur_hold = 1'b0;
        restart_parse();
        foreach (pool_shadow[k])
            pool_shadow[k] = '0;

        foreach (DIRECTED[k])
            build_row(DIRECTED[k]);
        // Largest pool the core holds, walked once
        build_row('{FILE_FULL_POOL, 16'h0000, 16'h0000, 1'b0, ST_OK});

        // Back-to-back one-byte files while the output is held off: each owes a word,
        // so the result queue fills and the input has to stall
        cur_typed = 1'b0;
        cur_burst = 1'b1;
        cur_hold = 1'b1;
        repeat (40) add_byte($urandom, 1'b1);

        build_random_files();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (idx = 0; idx < stim_q.size(); idx++)
        begin
            it = stim_q[idx];
            gap = it.burst ? 0 : $urandom_range(0, 11);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
            @(negedge clk);
            if (it.hold)
                hold_req = 1'b1;
            s_tvalid <= 1'b1;
            s_tdata <= it.b;
            s_tlast <= it.eof;
            in_typed <= it.typed;
            in_want <= it.want;
            // Hold the word until the core takes it
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        // Drain: wait for every owed word, then give stray words time to show up
        while (pending_spans.size() != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Long output hold-off, counted here so the sender keeps pushing meanwhile
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // Output side: random stall per word, with calm stretches of none
    initial
    begin
        int stall;
        int rx_run;
        bit rx_calm;
        rx_run = 0;
        rx_calm = 1'b0;
        wait (rst_n);
        forever
        begin
            if (rx_run == 0)
            begin
                rx_calm = ($urandom_range(0, 2) == 0);
                rx_run = $urandom_range(4, 24);
            end
            rx_run--;
            stall = rx_calm ? 0 : $urandom_range(0, 11);
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            while (hold_rx)
            begin
                m_tready <= 1'b0;
                @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Predict on every accepted input word, check every accepted output word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                parse_class_byte(s_tdata, s_tlast, mon_got, mon_res);
                if (mon_got)
                    pending_spans.push_back(in_typed ? in_want : mon_res);
            end
            if (m_tvalid && m_tready)
            begin
                mon_seen = m_tdata[RESULT_W-1:0];
                if (pending_spans.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected span word: status %0d offset %0d length %0d class %0d",
                                 mon_seen.status, mon_seen.name_offset, mon_seen.name_length,
                                 mon_seen.class_index);
                end
                else
                begin
                    mon_want = pending_spans.pop_front();
                    if (mon_seen.status != mon_want.status
                        || mon_seen.name_offset != mon_want.name_offset
                        || mon_seen.name_length != mon_want.name_length
                        || mon_seen.class_index != mon_want.class_index)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("span mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     mon_want.status, mon_want.name_offset,
                                     mon_want.name_length, mon_want.class_index,
                                     mon_seen.status, mon_seen.name_offset,
                                     mon_seen.name_length, mon_seen.class_index);
                    end
                end
            end
        end
    end

    // Watchdog: give up when no word moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

endmodule

// ===== class_file_name_locator_core.f =====
hdl/cfnl_pkg.sv
hdl/cfnl_parser.sv
hdl/cfnl_resolve.sv
hdl/cfnl_outq.sv
hdl/class_file_name_locator_core.sv
hdl/cfnl_checker.sv
verif/tb_class_file_name_locator_core.sv
